[rtl/swt_pkg.sv]
`default_nettype none
package swt_pkg;

  localparam int unsigned DATA_BITS = 32;
  localparam logic [5:0] DATA_PERIOD = 6'(DATA_BITS + 1);
  localparam logic [5:0] REQ_PERIOD = 6'd8;
  localparam logic [5:0] ACK_PERIOD = 6'd3;
  localparam int unsigned REQ_RNW_BIT = 1;

  localparam logic [2:0] ACK_OK = 3'b001;
  localparam logic [2:0] ACK_WAIT = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  localparam logic [1:0] CFG_TURNAROUND = 2'd0;
  localparam logic [1:0] CFG_IDLE = 2'd1;
  localparam logic [1:0] CFG_FORCE = 2'd2;

  localparam logic OP_START = 1'b0;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_REQ     = 4'd1,
    PH_TURN1   = 4'd2,
    PH_ACK     = 4'd3,
    PH_RDATA   = 4'd4,
    PH_TURN2   = 4'd5,
    PH_WDATA   = 4'd6,
    PH_IDLEC   = 4'd7,
    PH_DUMMY_R = 4'd8,
    PH_DUMMY_W = 4'd9,
    PH_BACKOFF = 4'd10
  } phase_t;

  typedef struct packed {
    logic        line_out;
    logic        line_drive;
    logic        last;
    logic [2:0]  ack_bits;
    logic        parity_error;
    logic [DATA_BITS-1:0] read_data;
    logic        timestamp_strobe;
  } swt_result_t;

  function automatic phase_t next_phase(phase_t p, logic [2:0] ack, logic rd, logic frc);
    phase_t n;
    n = PH_IDLE;
    case (p)
      PH_REQ:   n = PH_TURN1;
      PH_TURN1: n = PH_ACK;
      PH_ACK: begin
        if (ack == ACK_OK) begin
          n = rd ? PH_RDATA : PH_TURN2;
        end else if (ack == ACK_WAIT || ack == ACK_FAULT) begin
          n = (frc && rd) ? PH_DUMMY_R : PH_TURN2;
        end else begin
          n = PH_BACKOFF;
        end
      end
      PH_RDATA:   n = PH_TURN2;
      PH_DUMMY_R: n = PH_TURN2;
      PH_TURN2: begin
        if (ack == ACK_OK) begin
          n = rd ? PH_IDLEC : PH_WDATA;
        end else begin
          n = (frc && !rd) ? PH_DUMMY_W : PH_IDLE;
        end
      end
      PH_WDATA: n = PH_IDLEC;
      default:  n = PH_IDLE;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[rtl/swt_core.sv]
`default_nettype none
module swt_core import swt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 accept,
  input  wire logic                 opcode,
  input  wire logic [3:0]           request,
  input  wire logic                 want_timestamp,
  input  wire logic [DATA_BITS-1:0] write_data,
  input  wire logic                 line_sample,
  output logic                      res_valid,
  output swt_result_t               res
);

  logic [2:0] turn_cfg_r;
  logic [7:0] idle_cfg_r;
  logic       force_cfg_r;

  phase_t               phase_r, phase_nxt;
  logic [5:0]           bit_cnt_r, bit_cnt_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic                 par_r, par_nxt;
  logic [2:0]           ack_r, ack_nxt;
  logic [3:0]           req_r, req_nxt;
  logic                 wish_r, wish_nxt;
  logic [7:0]           idle_cnt_r, idle_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_cfg_r  <= 3'd1;
      idle_cfg_r  <= 8'd0;
      force_cfg_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TURNAROUND: turn_cfg_r  <= cfg_data[2:0];
        CFG_IDLE:       idle_cfg_r  <= cfg_data;
        CFG_FORCE:      force_cfg_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    bit_cnt_r  <= bit_cnt_nxt;
    shift_r    <= shift_nxt;
    par_r      <= par_nxt;
    ack_r      <= ack_nxt;
    req_r      <= req_nxt;
    wish_r     <= wish_nxt;
    idle_cnt_r <= idle_cnt_nxt;
  end

  always_comb begin
    logic       lo;
    logic       drv;
    logic       strobe;
    logic       done;
    logic       ok_rd;
    logic [2:0] idx;
    phase_t     ent;
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    par_nxt      = par_r;
    ack_nxt      = ack_r;
    req_nxt      = req_r;
    wish_nxt     = wish_r;
    idle_cnt_nxt = idle_cnt_r;
    res_valid    = 1'b0;
    res          = '0;
    lo           = 1'b0;
    drv          = 1'b0;
    strobe       = 1'b0;
    done         = 1'b0;
    ok_rd        = 1'b0;
    idx          = 3'(REQ_PERIOD - bit_cnt_r);
    ent          = PH_IDLE;
    if (accept) begin
      if (opcode == OP_START) begin
        if (phase_r == PH_IDLE) begin
          req_nxt     = request;
          wish_nxt    = want_timestamp;
          shift_nxt   = write_data;
          par_nxt     = 1'b0;
          ack_nxt     = 3'd0;
          phase_nxt   = PH_REQ;
          bit_cnt_nxt = REQ_PERIOD;
        end
      end else if (phase_r != PH_IDLE) begin
        res_valid = 1'b1;
        case (phase_r)
          PH_REQ: begin
            drv = 1'b1;
            case (idx)
              3'd0:    lo = 1'b1;
              3'd1:    lo = req_r[0];
              3'd2:    lo = req_r[1];
              3'd3:    lo = req_r[2];
              3'd4:    lo = req_r[3];
              3'd5:    lo = ^req_r;
              3'd6:    lo = 1'b0;
              default: lo = 1'b1;
            endcase
          end
          PH_ACK: begin
            ack_nxt = ack_r | (3'({2'b00, line_sample}) << (2'd3 - bit_cnt_r[1:0]));
          end
          PH_RDATA: begin
            if (bit_cnt_r > 6'd1) begin
              shift_nxt = {line_sample, shift_r[DATA_BITS-1:1]};
            end
            par_nxt = par_r ^ line_sample;
          end
          PH_WDATA: begin
            drv = 1'b1;
            if (bit_cnt_r > 6'd1) begin
              lo        = shift_r[0];
              shift_nxt = {1'b0, shift_r[DATA_BITS-1:1]};
              par_nxt   = par_r ^ shift_r[0];
            end else begin
              lo = par_r;
            end
          end
          PH_IDLEC, PH_DUMMY_W: drv = 1'b1;
          default: ;
        endcase

        if (phase_r == PH_IDLEC) begin
          if (idle_cnt_r != 8'd0) begin
            idle_cnt_nxt = idle_cnt_r - 8'd1;
          end
          done = (idle_cnt_nxt == 8'd0);
        end else begin
          if (bit_cnt_r != 6'd0) begin
            bit_cnt_nxt = bit_cnt_r - 6'd1;
          end
          done = (bit_cnt_nxt == 6'd0);
        end

        if (done) begin
          // zero-length phases are skipped in the same beat
          ent = next_phase(phase_r, ack_nxt, req_r[REQ_RNW_BIT], force_cfg_r);
          if (ent == PH_TURN1 && turn_cfg_r == 3'd0) begin
            ent = PH_ACK;
          end
          if (ent == PH_TURN2 && turn_cfg_r == 3'd0) begin
            ent = next_phase(PH_TURN2, ack_nxt, req_r[REQ_RNW_BIT], force_cfg_r);
          end
          if (ent == PH_IDLEC && idle_cfg_r == 8'd0) begin
            ent = PH_IDLE;
          end
          phase_nxt = ent;
          case (ent)
            PH_REQ:                         bit_cnt_nxt = REQ_PERIOD;
            PH_TURN1, PH_TURN2:             bit_cnt_nxt = {3'b000, turn_cfg_r};
            PH_ACK:                         bit_cnt_nxt = ACK_PERIOD;
            PH_RDATA, PH_WDATA,
            PH_DUMMY_R, PH_DUMMY_W:         bit_cnt_nxt = DATA_PERIOD;
            PH_BACKOFF:                     bit_cnt_nxt = {3'b000, turn_cfg_r} + DATA_PERIOD;
            PH_IDLEC:                       idle_cnt_nxt = idle_cfg_r;
            default:                        bit_cnt_nxt = 6'd0;
          endcase
          strobe = (ack_nxt == ACK_OK) && wish_r && (phase_r != PH_IDLEC) &&
                   (ent == PH_IDLEC || ent == PH_IDLE);
        end

        res.line_out         = lo;
        res.line_drive       = drv;
        res.last             = (phase_nxt == PH_IDLE);
        ok_rd                = res.last && (ack_nxt == ACK_OK) && req_r[REQ_RNW_BIT];
        res.ack_bits         = res.last ? ack_nxt : 3'd0;
        res.parity_error     = ok_rd ? par_nxt : 1'b0;
        res.read_data        = ok_rd ? shift_nxt : '0;
        res.timestamp_strobe = strobe;
      end
    end
  end

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.last |=> phase_r == PH_IDLE)
    else $error("transfer end did not return to idle");

  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.line_drive |-> !res.line_out)
    else $error("released line shows a driven level");

  a_idlec_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLEC |-> idle_cnt_r != 8'd0)
    else $error("idle phase with empty counter");

  a_no_beat_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> !res_valid)
    else $error("result beat produced while idle");

endmodule
`default_nettype wire

[rtl/swt_out.sv]
`default_nettype none
module swt_out import swt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire swt_result_t  res,
  input  wire logic         out_ready,
  output logic              can_load,
  output logic              out_valid,
  output swt_result_t       out_res
);

  logic        valid_r, valid_nxt;
  swt_result_t data_r, data_nxt;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule
`default_nettype wire

[rtl/swd_wire_transfer_master.sv]
// A tick beat's result is registered and appears on out_* in the cycle after it is accepted.
// Throughput: one beat per cycle; in_ready drops only while a result is held
// and out_ready is low (single output register).
// Start beats and ticks while idle give no result.
// Reset (rst_n low, synchronous): idle, output empty, turnaround 1, idle clocks 0,
// dummy data phase off.
`default_nettype none
module swd_wire_transfer_master import swt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [3:0]           in_request,
  input  wire logic                 in_want_timestamp,
  input  wire logic [DATA_BITS-1:0] in_write_data,
  input  wire logic                 in_line_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_line_out,
  output logic                      out_line_drive,
  output logic                      out_last,
  output logic [2:0]                out_ack_bits,
  output logic                      out_parity_error,
  output logic [DATA_BITS-1:0]      out_read_data,
  output logic                      out_timestamp_strobe
);

  logic        accept;
  logic        res_valid;
  logic        can_load;
  swt_result_t res;
  swt_result_t out_res;

  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  swt_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .opcode         (in_opcode),
    .request        (in_request),
    .want_timestamp (in_want_timestamp),
    .write_data     (in_write_data),
    .line_sample    (in_line_sample),
    .res_valid      (res_valid),
    .res            (res)
  );

  swt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_line_out         = out_res.line_out;
  assign out_line_drive       = out_res.line_drive;
  assign out_last             = out_res.last;
  assign out_ack_bits         = out_res.ack_bits;
  assign out_parity_error     = out_res.parity_error;
  assign out_read_data        = out_res.read_data;
  assign out_timestamp_strobe = out_res.timestamp_strobe;

endmodule
`default_nettype wire
